FILE: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clock and held off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PRG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define PRG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/prg_pkg.sv
package prg_pkg;

   localparam int FracBits     = 16;
   localparam int CoordW       = 12;
   localparam int SideW        = 13;
   localparam int MaxImageSide = 4096;
   localparam int ScaleW       = 24;
   localparam int RowW         = 60;
   localparam int CoefW        = 20;
   localparam int DirW         = 20;
   localparam int RidW         = 24;
   localparam int CsrDataW     = 64;
   localparam int CsrAddrW     = 6;

   // pixel to unit coordinate divider
   localparam int CoordQuoW = FracBits + 2;
   localparam int CoordNumW = CoordW + CoordQuoW;
   // camera space component
   localparam int CAbsW  = FracBits + 1;
   localparam int CProdW = CAbsW + ScaleW;
   localparam int CMagW  = CProdW - FracBits;
   // vector length and normalizing divider
   localparam int RootW    = CMagW;
   localparam int NormQuoW = FracBits + 1;
   localparam int NormNumW = RootW + NormQuoW;
   localparam int NormW    = NormQuoW + 1;
   // matrix product
   localparam int MatProdW = CoefW + NormW;
   localparam int MatSumW  = MatProdW + 2;
   localparam int RndW     = MatSumW - FracBits;

   localparam logic signed [DirW-1:0] DirMax = {1'b0, {(DirW-1){1'b1}}};
   localparam logic signed [DirW-1:0] DirMin = {1'b1, {(DirW-1){1'b0}}};

   localparam logic [SideW-1:0]  ImageWidthReset  = SideW'(640);
   localparam logic [SideW-1:0]  ImageHeightReset = SideW'(480);
   localparam logic [ScaleW-1:0] ScaleReset       = ScaleW'(65536);
   localparam logic [RowW-1:0]   RowXReset        = RowW'(64'd65536);
   localparam logic [RowW-1:0]   RowYReset        = RowW'(64'd68719476736);
   localparam logic [RowW-1:0]   RowZReset        = RowW'(64'd72057594037927936);

   typedef enum logic [2:0] {
      CsrImageWidth,
      CsrImageHeight,
      CsrHorizScale,
      CsrVertScale,
      CsrMatrixRowX,
      CsrMatrixRowY,
      CsrMatrixRowZ
   } csr_idx_type;

   typedef struct packed {
      logic [RidW-1:0]        ray_id;
      logic signed [DirW-1:0] dir_x;
      logic signed [DirW-1:0] dir_y;
      logic signed [DirW-1:0] dir_z;
   } ray_type;

endpackage

FILE: hw/rtl/prg_div.sv
module prg_div #(
   parameter int DenW = prg_pkg::RootW,
   parameter int QuoW = prg_pkg::NormQuoW
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [DenW+QuoW-1:0] num,
   input  logic [DenW-1:0]      den,
   output logic [QuoW-1:0]      quo
);

   // restoring division, one quotient bit per stage, high bit first
   logic [DenW-1:0] rem_ff [QuoW];
   logic [DenW-1:0] den_ff [QuoW];
   logic [QuoW-1:0] low_ff [QuoW];
   logic [QuoW-1:0] quo_ff [QuoW];

   for (genvar s = 0; s < QuoW; s++) begin : g_step
      logic [DenW-1:0] rem_prev;
      logic [DenW-1:0] den_prev;
      logic [QuoW-1:0] low_prev;
      logic [QuoW-1:0] quo_prev;
      logic [DenW:0]   trial;
      logic            take;
      logic [DenW-1:0] rem_in;
      logic [QuoW-1:0] quo_in;

      if (s == 0) begin : g_head
         assign rem_prev = num[DenW+QuoW-1:QuoW];
         assign den_prev = den;
         assign low_prev = num[QuoW-1:0];
         assign quo_prev = '0;
      end else begin : g_tail
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign low_prev = low_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      assign trial  = {rem_prev, low_prev[QuoW-1-s]};
      assign take   = trial >= {1'b0, den_prev};
      assign rem_in = take ? DenW'(trial - {1'b0, den_prev}) : DenW'(trial);
      assign quo_in = {quo_prev[QuoW-2:0], take};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            low_ff[s] <= low_prev;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QuoW-1];

endmodule

FILE: hw/rtl/prg_isqrt.sv
module prg_isqrt #(
   parameter int RootW = prg_pkg::RootW
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [2*RootW-1:0]   rad,
   output logic [RootW-1:0]     root
);

   localparam int WorkW = 2 * RootW + 2;

   // digit recurrence, one result bit per stage
   logic [WorkW-1:0] rem_ff [RootW];
   logic [WorkW-1:0] res_ff [RootW];

   for (genvar s = 0; s < RootW; s++) begin : g_step
      localparam logic [WorkW-1:0] StepBit =
         {{(WorkW-1){1'b0}}, 1'b1} << (2 * (RootW - 1 - s));
      logic [WorkW-1:0] rem_prev;
      logic [WorkW-1:0] res_prev;
      logic [WorkW-1:0] trial;
      logic             take;
      logic [WorkW-1:0] rem_in;
      logic [WorkW-1:0] res_in;

      if (s == 0) begin : g_head
         assign rem_prev = {2'b00, rad};
         assign res_prev = '0;
      end else begin : g_tail
         assign rem_prev = rem_ff[s-1];
         assign res_prev = res_ff[s-1];
      end

      assign trial  = res_prev + StepBit;
      assign take   = rem_prev >= trial;
      assign rem_in = take ? rem_prev - trial : rem_prev;
      assign res_in = take ? (res_prev >> 1) + StepBit : res_prev >> 1;

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            res_ff[s] <= res_in;
         end
      end
   end

   assign root = res_ff[RootW-1][RootW-1:0];

endmodule

FILE: hw/rtl/primary_ray_generator.sv
// pinhole camera primary ray generator, one pixel word in, one ray word out
// throughput: one word per cycle while req_stall is low; most of the pipeline depth
// comes from the coordinate divider (18 stages), the square root (25 stages) and the
// normalizing divider (17 stages)
// reset: synchronous, clears the pipeline, output and skid valids, config goes to its defaults
`include "assert_macros.svh"

module primary_ray_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [prg_pkg::CoordW-1:0]          req_pixel_x,
   input  logic [prg_pkg::CoordW-1:0]          req_pixel_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [prg_pkg::RidW-1:0]            rsp_ray_id,
   output logic signed [prg_pkg::DirW-1:0]     rsp_dir_x,
   output logic signed [prg_pkg::DirW-1:0]     rsp_dir_y,
   output logic signed [prg_pkg::DirW-1:0]     rsp_dir_z,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prg_pkg::CsrAddrW-1:0]        csr_paddr,
   input  logic [prg_pkg::CsrDataW-1:0]        csr_pwdata,
   output logic [prg_pkg::CsrDataW-1:0]        csr_prdata,
   output logic                                csr_pready
);
   import prg_pkg::*;

   localparam int Depth = 2 + CoordQuoW + 5 + RootW + 1 + NormQuoW + 4;
   localparam logic [CoordQuoW-1:0] QOne = CoordQuoW'(1) << FracBits;
   localparam logic [CProdW-1:0] CHalf = CProdW'(1) << (FracBits - 1);
   localparam logic [2*RootW-1:0] ZSquare = (2*RootW)'(1) << (2 * FracBits);
   localparam logic [NormNumW-1:0] NumZBase = NormNumW'(1) << (2 * FracBits);
   localparam logic [MatSumW-1:0] MHalf = MatSumW'(1) << (FracBits - 1);
   localparam logic [RndW-1:0] PosLimit = RndW'(DirMax);
   localparam logic [RndW-1:0] NegLimit = RndW'({1'b1, {(DirW-1){1'b0}}});

   typedef struct packed {
      logic [RidW-1:0]  rid;
      logic             neg_x;
      logic             neg_y;
      logic [CMagW-1:0] mag_x;
      logic [CMagW-1:0] mag_y;
   } sq_side_type;

   typedef struct packed {
      logic [RidW-1:0] rid;
      logic            neg_x;
      logic            neg_y;
   } nd_side_type;

   // configuration
   logic [SideW-1:0]  image_width_ff;
   logic [SideW-1:0]  image_height_ff;
   logic [ScaleW-1:0] horiz_scale_ff;
   logic [ScaleW-1:0] vert_scale_ff;
   logic [RowW-1:0]   row_ff [3];
   logic              csr_wr;
   csr_idx_type       csr_idx;

   // pipeline control
   logic [Depth-1:0] valid_ff;
   logic             adv;
   logic             push;

   // entry
   logic [CoordW-1:0]    px_e0_ff, py_e0_ff;
   logic [SideW-1:0]     w_eff, h_eff;
   logic [CoordW-1:0]    span_w, span_h;
   logic [CoordW-1:0]    pcx, pcy;
   logic [CoordNumW-1:0] num_x_e1_ff, num_y_e1_ff;
   logic [RidW-1:0]      rid_e1_ff;
   logic [CoordQuoW-1:0] q_x, q_y;
   logic [RidW-1:0]      rid_dx_ff [CoordQuoW];

   // camera space
   logic             neg_x_c_ff [5];
   logic             neg_y_c_ff [5];
   logic [RidW-1:0]  rid_c_ff [5];
   logic [CAbsW-1:0] abs_x_c0_ff, abs_y_c0_ff;
   logic [CProdW-1:0] prod_x_c1_ff, prod_y_c1_ff;
   logic [CProdW-1:0] rnd_x, rnd_y;
   logic [CMagW-1:0] mag_x_c_ff [3];
   logic [CMagW-1:0] mag_y_c_ff [3];
   logic [2*CMagW-1:0] sq_x_c3_ff, sq_y_c3_ff;
   logic [2*RootW-1:0] len2_c4_ff;
   sq_side_type      sq_side;
   sq_side_type      sq_side_ff [RootW];
   logic [RootW-1:0] root;

   // normalize
   logic [NormNumW-1:0] num_n0_ff [3];
   logic [RootW-1:0]    len_n0_ff;
   nd_side_type         nd_side_n0_ff;
   nd_side_type         nd_side_ff [NormQuoW];
   logic [NormQuoW-1:0] q_n [3];

   // rotate
   logic signed [NormW-1:0]    n_d0_ff [3];
   logic signed [MatProdW-1:0] prod_d1_ff [3][3];
   logic signed [MatSumW-1:0]  sum_d2_ff [3];
   logic signed [DirW-1:0]     dir_d3_ff [3];
   logic [RidW-1:0]            rid_d_ff [4];
   logic [MatSumW-1:0]         mag_d3 [3];
   logic [MatSumW-1:0]         mrnd_d3 [3];
   logic signed [DirW-1:0]     dir_in [3];

   // output with skid word
   ray_type pipe_word;
   ray_type out_word_ff;
   ray_type skid_word_ff;
   logic    out_vld_ff;
   logic    skid_vld_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_idx_type'(csr_paddr[CsrAddrW-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= ImageWidthReset;
         image_height_ff <= ImageHeightReset;
         horiz_scale_ff  <= ScaleReset;
         vert_scale_ff   <= ScaleReset;
         row_ff[0]       <= RowXReset;
         row_ff[1]       <= RowYReset;
         row_ff[2]       <= RowZReset;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CsrImageWidth:  image_width_ff  <= csr_pwdata[SideW-1:0];
            CsrImageHeight: image_height_ff <= csr_pwdata[SideW-1:0];
            CsrHorizScale:  horiz_scale_ff  <= csr_pwdata[ScaleW-1:0];
            CsrVertScale:   vert_scale_ff   <= csr_pwdata[ScaleW-1:0];
            CsrMatrixRowX:  row_ff[0]       <= csr_pwdata[RowW-1:0];
            CsrMatrixRowY:  row_ff[1]       <= csr_pwdata[RowW-1:0];
            CsrMatrixRowZ:  row_ff[2]       <= csr_pwdata[RowW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CsrImageWidth:  csr_prdata = CsrDataW'(image_width_ff);
         CsrImageHeight: csr_prdata = CsrDataW'(image_height_ff);
         CsrHorizScale:  csr_prdata = CsrDataW'(horiz_scale_ff);
         CsrVertScale:   csr_prdata = CsrDataW'(vert_scale_ff);
         CsrMatrixRowX:  csr_prdata = CsrDataW'(row_ff[0]);
         CsrMatrixRowY:  csr_prdata = CsrDataW'(row_ff[1]);
         CsrMatrixRowZ:  csr_prdata = CsrDataW'(row_ff[2]);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;
   assign push      = adv && valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[Depth-2:0], req_valid};
      end
   end

   // ---------------- entry: side clamp, dividend, ray id ----------------
   always_comb begin
      priority if (image_width_ff < SideW'(2)) begin
         w_eff = SideW'(2);
      end else if (image_width_ff > SideW'(MaxImageSide)) begin
         w_eff = SideW'(MaxImageSide);
      end else begin
         w_eff = image_width_ff;
      end
      priority if (image_height_ff < SideW'(2)) begin
         h_eff = SideW'(2);
      end else if (image_height_ff > SideW'(MaxImageSide)) begin
         h_eff = SideW'(MaxImageSide);
      end else begin
         h_eff = image_height_ff;
      end
   end

   assign span_w = CoordW'(w_eff - SideW'(1));
   assign span_h = CoordW'(h_eff - SideW'(1));
   assign pcx    = (px_e0_ff > span_w) ? span_w : px_e0_ff;
   assign pcy    = (py_e0_ff > span_h) ? span_h : py_e0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px_e0_ff    <= req_pixel_x;
         py_e0_ff    <= req_pixel_y;
         num_x_e1_ff <= CoordNumW'({pcx, {(FracBits+1){1'b0}}}) + CoordNumW'(span_w >> 1);
         num_y_e1_ff <= CoordNumW'({pcy, {(FracBits+1){1'b0}}}) + CoordNumW'(span_h >> 1);
         rid_e1_ff   <= RidW'(py_e0_ff) * RidW'(w_eff) + RidW'(px_e0_ff);
      end
   end

   prg_div #(.DenW(CoordW), .QuoW(CoordQuoW)) u_div_x (
      .clock  (clock),
      .enable (adv),
      .num    (num_x_e1_ff),
      .den    (span_w),
      .quo    (q_x)
   );

   prg_div #(.DenW(CoordW), .QuoW(CoordQuoW)) u_div_y (
      .clock  (clock),
      .enable (adv),
      .num    (num_y_e1_ff),
      .den    (span_h),
      .quo    (q_y)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         rid_dx_ff[0] <= rid_e1_ff;
         for (int i = 1; i < CoordQuoW; i++) begin
            rid_dx_ff[i] <= rid_dx_ff[i-1];
         end
      end
   end

   // ---------------- camera space vector and squared length ----------------
   assign rnd_x = prod_x_c1_ff + CHalf;
   assign rnd_y = prod_y_c1_ff + CHalf;

   always_ff @(posedge clock) begin
      if (adv) begin
         // unit coordinate is q minus one, kept as sign and magnitude
         neg_x_c_ff[0] <= q_x < QOne;
         neg_y_c_ff[0] <= q_y < QOne;
         abs_x_c0_ff   <= (q_x < QOne) ? CAbsW'(QOne - q_x) : CAbsW'(q_x - QOne);
         abs_y_c0_ff   <= (q_y < QOne) ? CAbsW'(QOne - q_y) : CAbsW'(q_y - QOne);
         rid_c_ff[0]   <= rid_dx_ff[CoordQuoW-1];
         for (int i = 1; i < 5; i++) begin
            neg_x_c_ff[i] <= neg_x_c_ff[i-1];
            neg_y_c_ff[i] <= neg_y_c_ff[i-1];
            rid_c_ff[i]   <= rid_c_ff[i-1];
         end
         prod_x_c1_ff  <= CProdW'(abs_x_c0_ff) * CProdW'(horiz_scale_ff);
         prod_y_c1_ff  <= CProdW'(abs_y_c0_ff) * CProdW'(vert_scale_ff);
         mag_x_c_ff[0] <= rnd_x[CProdW-1:FracBits];
         mag_y_c_ff[0] <= rnd_y[CProdW-1:FracBits];
         for (int i = 1; i < 3; i++) begin
            mag_x_c_ff[i] <= mag_x_c_ff[i-1];
            mag_y_c_ff[i] <= mag_y_c_ff[i-1];
         end
         sq_x_c3_ff <= (2*CMagW)'(mag_x_c_ff[0]) * (2*CMagW)'(mag_x_c_ff[0]);
         sq_y_c3_ff <= (2*CMagW)'(mag_y_c_ff[0]) * (2*CMagW)'(mag_y_c_ff[0]);
         len2_c4_ff <= sq_x_c3_ff + sq_y_c3_ff + ZSquare;
      end
   end

   prg_isqrt #(.RootW(RootW)) u_isqrt (
      .clock  (clock),
      .enable (adv),
      .rad    (len2_c4_ff),
      .root   (root)
   );

   assign sq_side = '{rid:   rid_c_ff[4],
                      neg_x: neg_x_c_ff[4],
                      neg_y: neg_y_c_ff[4],
                      mag_x: mag_x_c_ff[2],
                      mag_y: mag_y_c_ff[2]};

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= sq_side;
         for (int i = 1; i < RootW; i++) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   // ---------------- normalize ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         num_n0_ff[0] <= NormNumW'({sq_side_ff[RootW-1].mag_x, {FracBits{1'b0}}})
                         + NormNumW'(root >> 1);
         num_n0_ff[1] <= NormNumW'({sq_side_ff[RootW-1].mag_y, {FracBits{1'b0}}})
                         + NormNumW'(root >> 1);
         num_n0_ff[2] <= NumZBase + NormNumW'(root >> 1);
         len_n0_ff    <= root;
         nd_side_n0_ff.rid   <= sq_side_ff[RootW-1].rid;
         nd_side_n0_ff.neg_x <= sq_side_ff[RootW-1].neg_x;
         nd_side_n0_ff.neg_y <= sq_side_ff[RootW-1].neg_y;
         nd_side_ff[0] <= nd_side_n0_ff;
         for (int i = 1; i < NormQuoW; i++) begin
            nd_side_ff[i] <= nd_side_ff[i-1];
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_norm
      prg_div #(.DenW(RootW), .QuoW(NormQuoW)) u_div_n (
         .clock  (clock),
         .enable (adv),
         .num    (num_n0_ff[k]),
         .den    (len_n0_ff),
         .quo    (q_n[k])
      );
   end

   // ---------------- rotate to world, round and saturate ----------------
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mag_d3[r]  = (sum_d2_ff[r] < 0) ? MatSumW'(-sum_d2_ff[r]) : MatSumW'(sum_d2_ff[r]);
         mrnd_d3[r] = mag_d3[r] + MHalf;
         if (sum_d2_ff[r] < 0) begin
            dir_in[r] = (mrnd_d3[r][MatSumW-1:FracBits] > NegLimit) ? DirMin
                      : DirW'(-$signed({1'b0, mrnd_d3[r][MatSumW-1:FracBits]}));
         end else begin
            dir_in[r] = (mrnd_d3[r][MatSumW-1:FracBits] > PosLimit) ? DirMax
                      : DirW'(mrnd_d3[r][MatSumW-1:FracBits]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_d0_ff[0] <= nd_side_ff[NormQuoW-1].neg_x ? NormW'(0) - NormW'(q_n[0])
                                                    : NormW'(q_n[0]);
         n_d0_ff[1] <= nd_side_ff[NormQuoW-1].neg_y ? NormW'(0) - NormW'(q_n[1])
                                                    : NormW'(q_n[1]);
         n_d0_ff[2] <= NormW'(q_n[2]);
         rid_d_ff[0] <= nd_side_ff[NormQuoW-1].rid;
         for (int i = 1; i < 4; i++) begin
            rid_d_ff[i] <= rid_d_ff[i-1];
         end
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_d1_ff[r][k] <= MatProdW'(signed'(row_ff[r][CoefW*k +: CoefW]))
                                   * MatProdW'(n_d0_ff[k]);
            end
            sum_d2_ff[r] <= MatSumW'(prod_d1_ff[r][0]) + MatSumW'(prod_d1_ff[r][1])
                            + MatSumW'(prod_d1_ff[r][2]);
            dir_d3_ff[r] <= dir_in[r];
         end
      end
   end

   // ---------------- output register and skid word ----------------
   assign pipe_word = '{ray_id: rid_d_ff[3],
                        dir_x:  dir_d3_ff[0],
                        dir_y:  dir_d3_ff[1],
                        dir_z:  dir_d3_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || !rsp_stall) begin
         out_vld_ff  <= skid_vld_ff || push;
         skid_vld_ff <= 1'b0;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || !rsp_stall) begin
         out_word_ff <= skid_vld_ff ? skid_word_ff : pipe_word;
      end
      if (out_vld_ff && rsp_stall && push) begin
         skid_word_ff <= pipe_word;
      end
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_ray_id = out_word_ff.ray_id;
   assign rsp_dir_x  = out_word_ff.dir_x;
   assign rsp_dir_y  = out_word_ff.dir_y;
   assign rsp_dir_z  = out_word_ff.dir_z;

   `PRG_ASSERT_SAME(a_skid_behind_out, skid_vld_ff, out_vld_ff, "skid word without output word")
   `PRG_ASSERT_NEXT(a_push_caught, push && out_vld_ff && rsp_stall, skid_vld_ff, "word lost at output")
   `PRG_ASSERT_NEXT(a_pipe_holds, skid_vld_ff, $stable(valid_ff), "pipeline moved while full")
   `PRG_ASSERT_SAME(a_skid_on_stall, $rose(skid_vld_ff), $past(rsp_stall), "skid filled without stall")

endmodule

FILE: test/ray_checker.sv
`timescale 1ns / 100ps

module ray_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [prg_pkg::CoordW-1:0]          req_pixel_x,
   input  logic [prg_pkg::CoordW-1:0]          req_pixel_y,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [prg_pkg::RidW-1:0]            rsp_ray_id,
   input  logic signed [prg_pkg::DirW-1:0]     rsp_dir_x,
   input  logic signed [prg_pkg::DirW-1:0]     rsp_dir_y,
   input  logic signed [prg_pkg::DirW-1:0]     rsp_dir_z,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prg_pkg::CsrAddrW-1:0]        csr_paddr,
   input  logic [prg_pkg::CsrDataW-1:0]        csr_pwdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  pending
);
   import prg_pkg::*;

   logic [SideW-1:0]  width_reg;
   logic [SideW-1:0]  height_reg;
   logic [ScaleW-1:0] hscale_reg;
   logic [ScaleW-1:0] vscale_reg;
   logic [RowW-1:0]   row_reg [3];

   ray_type expected_rays [$];
   int      errs;

   function automatic longint drop_frac(longint v);
      longint m;
      m = ((v < 0 ? -v : v) + 64'sd32768) >>> FracBits;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint clip_side(logic [SideW-1:0] s);
      if (s < 2) return 2;
      if (s > MaxImageSide) return MaxImageSide;
      return longint'(s);
   endfunction

   // pixel to [-1, 1] in Q.16
   function automatic longint pixel_to_unit(longint p, longint side);
      longint span;
      span = side - 1;
      if (p > span) p = span;
      return ((p <<< (FracBits + 1)) + span / 2) / span - (64'sd1 <<< FracBits);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      for (int k = 0; k < 32; k++) begin
         b = 64'd1 << (62 - 2 * k);
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   function automatic logic [DirW-1:0] rotate_row(logic [RowW-1:0] row, longint n [3]);
      longint acc;
      logic [CoefW-1:0] raw;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
         raw = row[CoefW*k +: CoefW];
         acc += longint'($signed(raw)) * n[k];
      end
      acc = drop_frac(acc);
      if (acc > longint'(DirMax)) acc = longint'(DirMax);
      if (acc < longint'(DirMin)) acc = longint'(DirMin);
      return acc[DirW-1:0];
   endfunction

   function automatic ray_type trace_pixel(logic [CoordW-1:0] px, logic [CoordW-1:0] py);
      ray_type r;
      longint w, h, len;
      longint c [3];
      longint n [3];
      longint unsigned sq, m, q;
      longint id;
      w = clip_side(width_reg);
      h = clip_side(height_reg);
      c[0] = drop_frac(pixel_to_unit(px, w) * longint'(hscale_reg));
      c[1] = drop_frac(pixel_to_unit(py, h) * longint'(vscale_reg));
      c[2] = 64'sd1 <<< FracBits;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         m = c[i] < 0 ? -c[i] : c[i];
         sq += m * m;
      end
      len = longint'(root_floor(sq));
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
         m = c[i] < 0 ? -c[i] : c[i];
         q = ((m << FracBits) + len / 2) / len;
         n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      id = longint'(py) * w + longint'(px);
      r.ray_id = id[RidW-1:0];
      r.dir_x = rotate_row(row_reg[0], n);
      r.dir_y = rotate_row(row_reg[1], n);
      r.dir_z = rotate_row(row_reg[2], n);
      return r;
   endfunction

   always @(posedge clock) begin
      ray_type want;
      ray_type got;
      if (reset) begin
         width_reg = ImageWidthReset;
         height_reg = ImageHeightReset;
         hscale_reg = ScaleReset;
         vscale_reg = ScaleReset;
         row_reg[0] = RowXReset;
         row_reg[1] = RowYReset;
         row_reg[2] = RowZReset;
         expected_rays.delete();
         errs = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_idx_type'(csr_paddr[5:3]))
               CsrImageWidth:  width_reg = csr_pwdata[SideW-1:0];
               CsrImageHeight: height_reg = csr_pwdata[SideW-1:0];
               CsrHorizScale:  hscale_reg = csr_pwdata[ScaleW-1:0];
               CsrVertScale:   vscale_reg = csr_pwdata[ScaleW-1:0];
               CsrMatrixRowX:  row_reg[0] = csr_pwdata[RowW-1:0];
               CsrMatrixRowY:  row_reg[1] = csr_pwdata[RowW-1:0];
               CsrMatrixRowZ:  row_reg[2] = csr_pwdata[RowW-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_rays.insert(expected_rays.size(), trace_pixel(req_pixel_x, req_pixel_y));
         if (rsp_valid && !rsp_stall) begin
            got.ray_id = rsp_ray_id;
            got.dir_x = rsp_dir_x;
            got.dir_y = rsp_dir_y;
            got.dir_z = rsp_dir_z;
            if (expected_rays.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("unexpected ray word: id %0d dir %0d %0d %0d",
                           got.ray_id, got.dir_x, got.dir_y, got.dir_z);
            end else begin
               want = expected_rays.pop_front();
               if (want.ray_id !== got.ray_id || want.dir_x !== got.dir_x ||
                   want.dir_y !== got.dir_y || want.dir_z !== got.dir_z) begin
                  errs++;
                  if (errs <= 10)
                     $display("ray mismatch: id %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d (exp/act)",
                              want.ray_id, got.ray_id, want.dir_x, got.dir_x,
                              want.dir_y, got.dir_y, want.dir_z, got.dir_z);
               end
            end
         end
      end
      fail_count <= errs;
      pending <= expected_rays.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import prg_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CoordW-1:0] req_pixel_x;
   logic [CoordW-1:0] req_pixel_y;
   logic rsp_valid;
   logic rsp_stall;
   logic [RidW-1:0] rsp_ray_id;
   logic signed [DirW-1:0] rsp_dir_x;
   logic signed [DirW-1:0] rsp_dir_y;
   logic signed [DirW-1:0] rsp_dir_z;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic csr_pready;

   int fail_count;
   int pending;
   bit quiet;
   bit hold_rsp;
   int cur_w;
   int cur_h;
   int idle_cycles;

   primary_ray_generator u_dut (.*);

   ray_checker u_chk (
      .clock, .reset, .req_valid, .req_stall, .req_pixel_x, .req_pixel_y,
      .rsp_valid, .rsp_stall, .rsp_ray_id, .rsp_dir_x, .rsp_dir_y, .rsp_dir_z,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver back-pressure, with one long hold-off on request
   initial begin
      int g;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
            rsp_stall = 0;
         end else if (quiet) begin
            rsp_stall = 0;
         end else begin
            g = pick_gap();
            rsp_stall = g > 0;
            if (g > 1) repeat (g - 1) @(negedge clock);
         end
      end
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("** primary_ray_generator: FAILED **");
         $finish;
      end
   end

   task automatic send_pixel(int px, int py);
      int g;
      g = quiet ? 0 : pick_gap();
      if (g > 0) begin
         req_valid = 0;
         repeat (g) @(negedge clock);
      end
      req_valid = 1;
      req_pixel_x = px[CoordW-1:0];
      req_pixel_y = py[CoordW-1:0];
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [63:0] val);
      csr_psel = 1;
      csr_penable = 0;
      csr_pwrite = 1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   function automatic int clip(logic [SideW-1:0] s);
      if (s < 2) return 2;
      if (s > MaxImageSide) return MaxImageSide;
      return int'(s);
   endfunction

   task automatic set_view(logic [63:0] w, logic [63:0] h, logic [63:0] hs,
                           logic [63:0] vs, logic [63:0] rx, logic [63:0] ry,
                           logic [63:0] rz);
      csr_write(CsrImageWidth, w);
      csr_write(CsrImageHeight, h);
      csr_write(CsrHorizScale, hs);
      csr_write(CsrVertScale, vs);
      csr_write(CsrMatrixRowX, rx);
      csr_write(CsrMatrixRowY, ry);
      csr_write(CsrMatrixRowZ, rz);
      cur_w = clip(w[SideW-1:0]);
      cur_h = clip(h[SideW-1:0]);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] row_of(logic [19:0] a, logic [19:0] b, logic [19:0] c);
      return {4'h0, c, b, a};
   endfunction

   task automatic random_pixel();
      if ($urandom_range(0, 99) < 15)
         send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      else
         send_pixel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_pixel_x = 0;
      req_pixel_y = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      quiet = 0;
      hold_rsp = 0;
      cur_w = 640;
      cur_h = 480;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // corners, center and out-of-image pixels at the default view
      send_pixel(0, 0);
      send_pixel(639, 479);
      send_pixel(0, 479);
      send_pixel(639, 0);
      send_pixel(320, 240);
      send_pixel(319, 239);
      send_pixel(4095, 4095);
      send_pixel(640, 480);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(2730, 1365);
      send_pixel(1365, 2730);
      drain();

      // out-of-range sides, max and zero scales, min/max coefficients saturate
      set_view(0, 1, 24'hFFFFFF, 24'hFFFFFF, row_of(20'h7FFFF, 20'h80000, 20'h7FFFF),
               row_of(20'h80000, 20'h80000, 20'h80000), row_of(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
      send_pixel(0, 0);
      send_pixel(1, 1);
      send_pixel(4095, 4095);
      send_pixel(0, 1);
      drain();
      set_view(8191, 4096, 0, 0, row_of(20'h7FFFF, 20'h7FFFF, 20'h7FFFF),
               row_of(20'h80000, 20'h80000, 20'h80000), rand64());
      send_pixel(4095, 4095);
      send_pixel(0, 0);
      send_pixel(2048, 4095);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         quiet = (ph == 2);
         case (ph)
            0: set_view(2, 2, $urandom_range(1 << 14, 1 << 18), $urandom_range(1 << 14, 1 << 18),
                        rand64(), rand64(), rand64());
            1: set_view(4096, 4096, 24'hFFFFFF, 24'hFFFFFF, rand64(), rand64(), rand64());
            default: set_view(rand64(), $urandom_range(2, 64),
                              $urandom_range(0, 1) ? rand64() : $urandom_range(0, 1 << 18),
                              $urandom_range(0, 1) ? rand64() : $urandom_range(0, 1 << 18),
                              $urandom_range(0, 1) ? rand64()
                                 : row_of(20'(1 << 16), 20'($urandom_range(0, 1 << 15)),
                                          20'(0)),
                              rand64(), rand64());
         endcase
         for (int i = 0; i < 240; i++) begin
            if (ph == 3 && i == 20) hold_rsp = 1;
            if (ph == 5 && i == 120) drain();
            random_pixel();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("** primary_ray_generator: PASSED **");
      end else begin
         $display("** primary_ray_generator: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/prg_pkg.sv
hw/rtl/prg_div.sv
hw/rtl/prg_isqrt.sv
hw/rtl/primary_ray_generator.sv
test/ray_checker.sv
test/tb_top.sv
